/* rtl/qpe_pkg.sv */
// ---------------------------------------------------------------------------
// qpe_pkg: shared types and helpers for the query parameter extractor
// Character codes, register indexes, the result record and small
// ASCII helpers used by the form decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package qpe_pkg;

  // Name storage
  localparam int unsigned MAX_NAME_BYTES = 16;
  localparam int unsigned NAME_LEN_W     = 5;
  localparam int unsigned OCC_W          = 16;

  // Result queue sizing: one byte yields at most three results
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register indexes (paddr[4:3])
  localparam logic [1:0] REG_NAME_LO = 2'd0;
  localparam logic [1:0] REG_NAME_HI = 2'd1;
  localparam logic [1:0] REG_NAME_LEN = 2'd2;
  localparam logic [1:0] REG_OCC_IDX = 2'd3;

  // Character codes
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_W     = 8'h57;  // 'W', 'a' minus ten
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_F  = 8'h46;  // 'F'
  localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_F  = 8'h66;  // 'f'
  localparam logic [7:0] CASE_BIT = 8'h20;

  // One result beat
  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       end_of_value;
    logic       found;
  } result_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic is_upper;
    is_upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
    return is_upper ? (c | CASE_BIT) : c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
           ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] diff;
    lc   = lower_ascii(c);
    diff = (lc <= CH_NINE) ? (lc - CH_ZERO) : (lc - CH_W);
    return diff[3:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/query_parameter_extractor.sv */
// ---------------------------------------------------------------------------
// query_parameter_extractor: pick one query parameter and form-decode it
// Matches a configured name (case-insensitive) at each segment start,
// counts occurrences and streams the selected value, decoded, ending
// each query with one end beat that carries the found flag.
// ---------------------------------------------------------------------------
//  channel | ports                              | beat
//  --------+------------------------------------+-------------------------
//  in      | in_valid / in_stall                | one raw query byte
//  out     | out_valid / out_stall              | one decoded result
//  cfg     | psel penable pwrite paddr pwdata   | 64-bit register access
//
//  Each byte is parsed in the cycle it is accepted; its zero to three
//  results land in a four-entry result queue the same edge.
//  Input is taken while at most one result is queued, so bytes that give
//  at most one result go through at one per cycle while out_stall is low;
//  a byte giving two or three results holds the input for queue drain.
//  Synchronous active-low reset empties the queue and starts a new query.
//  out_stall only holds the queue head; input stalls once two are queued.
// ---------------------------------------------------------------------------
`default_nettype none

module query_parameter_extractor (
  input  wire         clk,
  input  wire         rst_n,
  // input bytes
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_final_byte,
  // results
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_value_byte,
  output logic        out_byte_valid,
  output logic        out_end_of_value,
  output logic        out_found,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    PH_QUERY,
    PH_NAME,
    PH_SKIP,
    PH_VALUE,
    PH_DONE
  } phase_t;

  localparam int unsigned CNT_W = $clog2(qpe_pkg::QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(qpe_pkg::QUEUE_DEPTH);
  localparam int unsigned RES_W = $clog2(qpe_pkg::MAX_RESULTS + 1);

  // Configuration
  logic [63:0]                     name_lo_r;
  logic [63:0]                     name_hi_r;
  logic [qpe_pkg::NAME_LEN_W-1:0]  name_len_r;
  logic [qpe_pkg::OCC_W-1:0]       occ_idx_r;

  // Parser state
  phase_t                          phase_r, phase_nxt;
  logic [qpe_pkg::NAME_LEN_W-1:0]  pos_r, pos_nxt;
  logic [qpe_pkg::OCC_W-1:0]       occ_r, occ_nxt;
  logic [1:0]                      pcnt_r, pcnt_nxt;
  logic [7:0]                      phex_r, phex_nxt;

  // Result queue, head at entry 0
  qpe_pkg::result_t                q_r   [qpe_pkg::QUEUE_DEPTH];
  qpe_pkg::result_t                q_nxt [qpe_pkg::QUEUE_DEPTH];
  logic [CNT_W-1:0]                count_r, count_nxt;

  // Step results
  qpe_pkg::result_t                res [qpe_pkg::MAX_RESULTS];
  logic [RES_W-1:0]                n_res;

  logic                            in_accept;
  logic                            out_pop;
  logic                            cfg_write;
  logic [1:0]                      cfg_idx;
  logic [qpe_pkg::NAME_LEN_W-1:0]  len_eff;
  logic [127:0]                    name_all;
  logic [7:0]                      name_byte;
  logic [7:0]                      b;
  logic                            do_fresh;
  logic                            do_finish;
  logic [CNT_W-1:0]                base;

  assign in_accept = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign in_stall  = (count_r > CNT_W'(1));

  assign out_value_byte   = q_r[0].value_byte;
  assign out_byte_valid   = q_r[0].byte_valid;
  assign out_end_of_value = q_r[0].end_of_value;
  assign out_found        = q_r[0].found;

  // Register port
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      qpe_pkg::REG_NAME_LO:  prdata = name_lo_r;
      qpe_pkg::REG_NAME_HI:  prdata = name_hi_r;
      qpe_pkg::REG_NAME_LEN: prdata = 64'(name_len_r);
      qpe_pkg::REG_OCC_IDX:  prdata = 64'(occ_idx_r);
      default:               prdata = '0;
    endcase
  end

  // Saturate name length and join the two name registers into one name
  assign len_eff  = (name_len_r > qpe_pkg::NAME_LEN_W'(qpe_pkg::MAX_NAME_BYTES)) ?
                    qpe_pkg::NAME_LEN_W'(qpe_pkg::MAX_NAME_BYTES) : name_len_r;
  assign name_all = {name_hi_r, name_lo_r};
  assign b        = in_data_byte;

  // Parse one byte: next state and up to three results
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    occ_nxt   = occ_r;
    pcnt_nxt  = pcnt_r;
    phex_nxt  = phex_r;
    n_res     = '0;
    do_fresh  = 1'b0;
    do_finish = 1'b0;
    for (int i = 0; i < qpe_pkg::MAX_RESULTS; i++) begin
      res[i] = '0;
    end

    // open a new query
    if (phase_nxt == PH_QUERY) begin
      occ_nxt   = occ_idx_r;
      pos_nxt   = '0;
      phase_nxt = PH_NAME;
    end

    name_byte = name_all[{pos_nxt[3:0], 3'b000} +: 8];

    unique case (phase_nxt)
      PH_NAME: begin
        if (pos_nxt < len_eff) begin
          if (qpe_pkg::lower_ascii(b) == qpe_pkg::lower_ascii(name_byte)) begin
            pos_nxt = pos_nxt + 1'b1;
          end else if (b == qpe_pkg::CH_AMP) begin
            pos_nxt = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else if (b == qpe_pkg::CH_EQ) begin
          if (occ_nxt == '0) begin
            phase_nxt = PH_VALUE;
            pcnt_nxt  = '0;
          end else begin
            occ_nxt   = occ_nxt - 1'b1;
            phase_nxt = PH_SKIP;
          end
        end else if (b == qpe_pkg::CH_AMP) begin
          pos_nxt = '0;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == qpe_pkg::CH_AMP) begin
          phase_nxt = PH_NAME;
          pos_nxt   = '0;
        end
      end
      PH_VALUE: begin
        if (b == qpe_pkg::CH_AMP) begin
          phase_nxt = PH_DONE;
          do_finish = 1'b1;
        end else if (pcnt_nxt == 2'd2) begin
          if (qpe_pkg::is_hex(b)) begin
            res[n_res] = '{value_byte: {qpe_pkg::hex_value(phex_nxt), qpe_pkg::hex_value(b)},
                           byte_valid: 1'b1, end_of_value: 1'b0, found: 1'b0};
            n_res      = n_res + 1'b1;
            pcnt_nxt   = '0;
          end else begin
            // flush the held escape literally
            res[n_res] = '{value_byte: qpe_pkg::CH_PCT, byte_valid: 1'b1,
                           end_of_value: 1'b0, found: 1'b0};
            n_res      = n_res + 1'b1;
            res[n_res] = '{value_byte: phex_nxt, byte_valid: 1'b1,
                           end_of_value: 1'b0, found: 1'b0};
            n_res      = n_res + 1'b1;
            pcnt_nxt   = '0;
            do_fresh   = 1'b1;
          end
        end else if (pcnt_nxt == 2'd1) begin
          if (qpe_pkg::is_hex(b)) begin
            phex_nxt = b;
            pcnt_nxt = 2'd2;
          end else begin
            res[n_res] = '{value_byte: qpe_pkg::CH_PCT, byte_valid: 1'b1,
                           end_of_value: 1'b0, found: 1'b0};
            n_res      = n_res + 1'b1;
            pcnt_nxt   = '0;
            do_fresh   = 1'b1;
          end
        end else begin
          do_fresh = 1'b1;
        end

        // plain value byte
        if (do_fresh) begin
          if (b == qpe_pkg::CH_PCT) begin
            pcnt_nxt = 2'd1;
          end else begin
            res[n_res] = '{value_byte: (b == qpe_pkg::CH_PLUS) ? qpe_pkg::CH_SPACE : b,
                           byte_valid: 1'b1, end_of_value: 1'b0, found: 1'b0};
            n_res      = n_res + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (in_final_byte && (phase_nxt == PH_VALUE)) begin
      do_finish = 1'b1;
    end

    // close the value: flush held bytes, mark the last beat
    if (do_finish) begin
      if (pcnt_nxt != 2'd0) begin
        res[n_res] = '{value_byte: qpe_pkg::CH_PCT, byte_valid: 1'b1,
                       end_of_value: 1'b0, found: 1'b0};
        n_res      = n_res + 1'b1;
      end
      if (pcnt_nxt == 2'd2) begin
        res[n_res] = '{value_byte: phex_nxt, byte_valid: 1'b1,
                       end_of_value: 1'b0, found: 1'b0};
        n_res      = n_res + 1'b1;
      end
      pcnt_nxt = '0;
      phex_nxt = '0;
      if (n_res != '0) begin
        res[n_res - 1'b1].end_of_value = 1'b1;
        res[n_res - 1'b1].found        = 1'b1;
      end else begin
        res[0] = '{value_byte: 8'h00, byte_valid: 1'b0, end_of_value: 1'b1, found: 1'b1};
        n_res  = RES_W'(1);
      end
    end else if (in_final_byte && (phase_nxt != PH_DONE)) begin
      // no match in this query
      res[n_res] = '{value_byte: 8'h00, byte_valid: 1'b0, end_of_value: 1'b1, found: 1'b0};
      n_res      = n_res + 1'b1;
    end

    // restart after the last byte
    if (in_final_byte) begin
      phase_nxt = PH_QUERY;
      pos_nxt   = '0;
      occ_nxt   = occ_idx_r;
      pcnt_nxt  = '0;
      phex_nxt  = '0;
    end
  end

  // Result queue: shift out the head, append new results behind the rest
  always_comb begin
    base = count_r - CNT_W'(out_pop);
    for (int k = 0; k < qpe_pkg::QUEUE_DEPTH; k++) begin
      if (out_pop && (k < qpe_pkg::QUEUE_DEPTH - 1)) begin
        q_nxt[k] = q_r[(k + 1) % qpe_pkg::QUEUE_DEPTH];
      end else begin
        q_nxt[k] = q_r[k];
      end
      for (int j = 0; j < qpe_pkg::MAX_RESULTS; j++) begin
        if (in_accept && (RES_W'(j) < n_res) &&
            (base[IDX_W-1:0] + IDX_W'(j) == IDX_W'(k))) begin
          q_nxt[k] = res[j];
        end
      end
    end
    count_nxt = base + (in_accept ? CNT_W'(n_res) : CNT_W'(0));
  end

  // Hold state, configuration and the result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_lo_r  <= '0;
      name_hi_r  <= '0;
      name_len_r <= '0;
      occ_idx_r  <= '0;
      phase_r    <= PH_QUERY;
      pos_r      <= '0;
      occ_r      <= '0;
      pcnt_r     <= '0;
      phex_r     <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_idx)
          qpe_pkg::REG_NAME_LO:  name_lo_r  <= pwdata;
          qpe_pkg::REG_NAME_HI:  name_hi_r  <= pwdata;
          qpe_pkg::REG_NAME_LEN: name_len_r <= pwdata[qpe_pkg::NAME_LEN_W-1:0];
          qpe_pkg::REG_OCC_IDX:  occ_idx_r  <= pwdata[qpe_pkg::OCC_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        occ_r   <= occ_nxt;
        pcnt_r  <= pcnt_nxt;
        phex_r  <= phex_nxt;
      end
      count_r <= count_nxt;
    end
    for (int k = 0; k < qpe_pkg::QUEUE_DEPTH; k++) begin
      q_r[k] <= q_nxt[k];
    end
  end

`ifndef SYNTHESIS
  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(qpe_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // found only rides on an end beat
  a_found_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_end_of_value)
    else $error("found without end_of_value");

  // a beat without a byte is an end marker with zero data
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_end_of_value && (out_value_byte == 8'h00))
    else $error("bare beat is not a clean end marker");

  // held escape bytes exist only inside a value
  a_pending_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r != 2'd0 |-> phase_r == PH_VALUE)
    else $error("escape held outside a value");
`endif

endmodule

`default_nettype wire
